### design/abtp_pkg.sv
// Shared types and constants for the angle-between-two-points CORDIC core.
// Holds the arctangent table, the fixed internal widths and the vector record
// that travels down the micro-rotation chain. Depends on nothing.
package abtp_pkg;

	// Angle accumulator fraction bits and the normalised magnitude exponent.
	localparam int TABLE_FRAC = 24;
	localparam int NORM_BITS  = 40;

	// Normalised vectors sit below 2^41 and grow by the CORDIC gain and root two.
	localparam int XY_BITS    = 45;
	localparam int Z_BITS     = 32;
	localparam int SHIFT_BITS = 6;

	// Ninety degrees at the accumulator scale.
	localparam logic signed [Z_BITS-1:0] Z_RIGHT = 32'sd1509949440;

	typedef struct packed {
		logic dx_zero;
		logic dx_neg;
		logic dy_zero;
		logic dy_neg;
	} quad_t;

	typedef struct packed {
		quad_t                      quad;
		logic signed [XY_BITS-1:0] x;
		logic signed [XY_BITS-1:0] y;
		logic signed [Z_BITS-1:0]  z;
	} cordic_t;

	// atan(2^-i) in degrees, scaled by 2^24.
	function automatic logic signed [Z_BITS-1:0] atan_deg(input int idx);
		logic signed [Z_BITS-1:0] val;
		case (idx)
			0:       val = 32'sd754974720;
			1:       val = 32'sd445687602;
			2:       val = 32'sd235489088;
			3:       val = 32'sd119537938;
			4:       val = 32'sd60000934;
			5:       val = 32'sd30029717;
			6:       val = 32'sd15018523;
			7:       val = 32'sd7509720;
			8:       val = 32'sd3754917;
			9:       val = 32'sd1877466;
			10:      val = 32'sd938734;
			11:      val = 32'sd469367;
			12:      val = 32'sd234684;
			13:      val = 32'sd117342;
			14:      val = 32'sd58671;
			15:      val = 32'sd29335;
			16:      val = 32'sd14668;
			17:      val = 32'sd7334;
			18:      val = 32'sd3667;
			19:      val = 32'sd1833;
			20:      val = 32'sd917;
			21:      val = 32'sd458;
			22:      val = 32'sd229;
			23:      val = 32'sd115;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

### design/abtp_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
// Depends on abtp_pkg for the vector record and the arctangent table.
module abtp_cordic_stage import abtp_pkg::*; #(
	parameter int STAGE_IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_in,
	input  cordic_t vec_in,
	output logic    valid_out,
	output cordic_t vec_out
);

	logic signed [XY_BITS-1:0] x_shr;
	logic signed [XY_BITS-1:0] y_shr;
	logic signed [Z_BITS-1:0]  ang;
	cordic_t                   vec_d;
	cordic_t                   vec_s1;
	logic                      valid_s1;

	always_comb begin
		x_shr      = $signed(vec_in.x) >>> STAGE_IDX;
		y_shr      = $signed(vec_in.y) >>> STAGE_IDX;
		ang        = atan_deg(STAGE_IDX);
		vec_d.quad = vec_in.quad;
		// Rotate towards the x axis; the sign of y picks the direction.
		if (!vec_in.y[XY_BITS-1]) begin
			vec_d.x = vec_in.x + y_shr;
			vec_d.y = vec_in.y - x_shr;
			vec_d.z = vec_in.z + ang;
		end else begin
			vec_d.x = vec_in.x - y_shr;
			vec_d.y = vec_in.y + x_shr;
			vec_d.z = vec_in.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_d;
	end

	assign valid_out = valid_s1;
	assign vec_out   = vec_s1;

endmodule

### design/angle_between_two_points_core.sv
// Heading from a start point to an end point in fixed-point degrees, by CORDIC vectoring.
// A transfer can start in every cycle while busy is low, so throughput is one per cycle.
// The depth grows with the unrolled micro-rotation chain, one register stage per rotation.
// busy is high only while reset is applied and in the first cycle after it; the receiver
// cannot stall, so done follows every accepted transfer. Reset clears all valid bits.
module angle_between_two_points_core import abtp_pkg::*; #(
	parameter int COORD_BITS      = 20,
	parameter int CORDIC_STAGES   = 16,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_BITS-1:0]      start_x,
	input  logic signed [COORD_BITS-1:0]      start_y,
	input  logic signed [COORD_BITS-1:0]      end_x,
	input  logic signed [COORD_BITS-1:0]      end_y,
	output logic                              done,
	output logic signed [ANGLE_FRAC_BITS+8:0] heading
);

	// Differences need one bit more than the coordinates; their magnitudes fit in the same width.
	localparam int CW     = COORD_BITS + 1;
	localparam int OUT_W  = ANGLE_FRAC_BITS + 9;
	localparam int Q_W    = ANGLE_FRAC_BITS + 8;
	localparam int RND_SH = TABLE_FRAC - ANGLE_FRAC_BITS;
	localparam int LAT    = CORDIC_STAGES + 6;

	localparam logic signed [Z_BITS-1:0] RND_HALF  = Z_BITS'(1 << (RND_SH - 1));
	localparam logic [Q_W-1:0]           FULL_ANG  = Q_W'(180 << ANGLE_FRAC_BITS);
	localparam logic [Q_W-1:0]           RIGHT_ANG = Q_W'(90 << ANGLE_FRAC_BITS);

	// Index of the highest set bit; zero for a zero word.
	function automatic logic [SHIFT_BITS-1:0] msb_pos(input logic [CW-1:0] v);
		logic [SHIFT_BITS-1:0] p;
		p = '0;
		for (int b = 0; b < CW; b++) begin
			if (v[b]) begin
				p = SHIFT_BITS'(b);
			end
		end
		return p;
	endfunction

	logic accept;
	logic busy_q;

	// Stage 1: coordinate differences.
	logic                 valid_s1;
	logic signed [CW-1:0] dx_s1;
	logic signed [CW-1:0] dy_s1;

	// Stage 2: magnitudes and quadrant flags.
	logic          valid_s2;
	logic [CW-1:0] ax_s2;
	logic [CW-1:0] ay_s2;
	quad_t         quad_s2;
	logic [CW-1:0] ax_d;
	logic [CW-1:0] ay_d;
	quad_t         quad_d;

	// Stage 3: normalising shift amount.
	logic                  valid_s3;
	logic [CW-1:0]         ax_s3;
	logic [CW-1:0]         ay_s3;
	quad_t                 quad_s3;
	logic [SHIFT_BITS-1:0] shamt_s3;
	logic [SHIFT_BITS-1:0] px_d;
	logic [SHIFT_BITS-1:0] py_d;
	logic [SHIFT_BITS-1:0] pmax_d;

	// Stage 4: normalised vector, head of the rotation chain.
	logic    valid_s4;
	cordic_t vec_s4;
	cordic_t vec4_d;

	// Rotation chain taps.
	logic    chain_valid [0:CORDIC_STAGES];
	cordic_t chain_vec   [0:CORDIC_STAGES];

	// Stage 5: clamped and rounded first-quadrant magnitude.
	logic                     valid_s5;
	logic [Q_W-1:0]           q_s5;
	quad_t                    quad_s5;
	cordic_t                  tail_vec;
	logic signed [Z_BITS-1:0] zc_d;
	logic signed [Z_BITS-1:0] zr_d;

	// Stage 6: quadrant applied, driven straight onto the result ports.
	logic                    done_s6;
	logic signed [OUT_W-1:0] heading_s6;
	logic signed [OUT_W-1:0] q_ext;
	logic signed [OUT_W-1:0] full_ext;
	logic signed [OUT_W-1:0] right_ext;
	logic signed [OUT_W-1:0] r_d;

	// The pipeline never stalls, so busy only covers the cycle leaving reset.
	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_s6  <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= chain_valid[CORDIC_STAGES];
			done_s6  <= valid_s5;
		end
	end

	// Stage 2 logic: absolute values and the signs that fix the quadrant later.
	always_comb begin
		ax_d           = dx_s1[CW-1] ? (~dx_s1 + 1'b1) : dx_s1;
		ay_d           = dy_s1[CW-1] ? (~dy_s1 + 1'b1) : dy_s1;
		quad_d.dx_zero = (dx_s1 == '0);
		quad_d.dx_neg  = dx_s1[CW-1];
		quad_d.dy_zero = (dy_s1 == '0);
		quad_d.dy_neg  = dy_s1[CW-1];
	end

	// Stage 3 logic: the larger magnitude sets the shift that lifts it to 2^40.
	always_comb begin
		px_d   = msb_pos(ax_s2);
		py_d   = msb_pos(ay_s2);
		pmax_d = (px_d > py_d) ? px_d : py_d;
	end

	// Stage 4 logic: both components take the same shift, so the ratio is kept.
	always_comb begin
		vec4_d.quad = quad_s3;
		vec4_d.x    = $signed(XY_BITS'(ax_s3) << shamt_s3);
		vec4_d.y    = $signed(XY_BITS'(ay_s3) << shamt_s3);
		vec4_d.z    = '0;
	end

	always_ff @(posedge clk) begin
		dx_s1    <= $signed({end_x[COORD_BITS-1], end_x}) -
			$signed({start_x[COORD_BITS-1], start_x});
		dy_s1    <= $signed({end_y[COORD_BITS-1], end_y}) -
			$signed({start_y[COORD_BITS-1], start_y});
		ax_s2    <= ax_d;
		ay_s2    <= ay_d;
		quad_s2  <= quad_d;
		ax_s3    <= ax_s2;
		ay_s3    <= ay_s2;
		quad_s3  <= quad_s2;
		shamt_s3 <= SHIFT_BITS'(NORM_BITS) - pmax_d;
		vec_s4   <= vec4_d;
		q_s5     <= zr_d[RND_SH +: Q_W];
		quad_s5  <= tail_vec.quad;
		heading_s6 <= r_d;
	end

	assign chain_valid[0] = valid_s4;
	assign chain_vec[0]   = vec_s4;

	// One registered micro-rotation per stage.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		abtp_cordic_stage #(
			.STAGE_IDX(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (chain_valid[i]),
			.vec_in   (chain_vec[i]),
			.valid_out(chain_valid[i+1]),
			.vec_out  (chain_vec[i+1])
		);
	end

	// Stage 5 logic: clamp the angle into the first quadrant, then round half up.
	always_comb begin
		tail_vec = chain_vec[CORDIC_STAGES];
		if (tail_vec.z[Z_BITS-1]) begin
			zc_d = '0;
		end else if (tail_vec.z > Z_RIGHT) begin
			zc_d = Z_RIGHT;
		end else begin
			zc_d = tail_vec.z;
		end
		zr_d = zc_d + RND_HALF;
	end

	// Stage 6 logic: map the first-quadrant magnitude onto the full circle.
	// A heading that rounds onto +180 degrees is given as -180, the same direction.
	always_comb begin
		q_ext     = $signed({1'b0, q_s5});
		full_ext  = $signed({1'b0, FULL_ANG});
		right_ext = $signed({1'b0, RIGHT_ANG});
		if (quad_s5.dx_zero) begin
			if (quad_s5.dy_zero) begin
				r_d = '0;
			end else if (quad_s5.dy_neg) begin
				r_d = -right_ext;
			end else begin
				r_d = right_ext;
			end
		end else if (!quad_s5.dx_neg) begin
			r_d = quad_s5.dy_neg ? -q_ext : q_ext;
		end else if (!quad_s5.dy_neg && !quad_s5.dy_zero) begin
			r_d = (q_s5 == '0) ? -full_ext : (full_ext - q_ext);
		end else begin
			r_d = q_ext - full_ext;
		end
	end

	assign done    = done_s6;
	assign heading = heading_s6;

	// Every accepted transfer comes out after the fixed latency, and nothing else does.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result missing after an accepted transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching accepted transfer");

	// The heading stays within [-180, 180) degrees.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading >= -$signed({1'b0, FULL_ANG})) && (heading < $signed({1'b0, FULL_ANG})))
		else $error("heading out of range");

endmodule
